### hdl/smcatr_pkg.sv
`timescale 1ns / 1ps

package smcatr_pkg;

    // Longest answer-to-reset accepted before a parse is flagged as too long
    localparam logic [5:0] MAX_ATR_BYTES = 6'd33;

    // Waiting integer used until TC2 is seen
    localparam logic [7:0] WAIT_DEFAULT = 8'd10;

    // Input item kinds (slave tuser)
    localparam logic [1:0] MODE_BYTE    = 2'd0;
    localparam logic [1:0] MODE_START   = 2'd1;
    localparam logic [1:0] MODE_TIMEOUT = 2'd2;

    // Result status codes (master tuser)
    localparam logic [2:0] ST_MORE     = 3'd0;
    localparam logic [2:0] ST_DONE     = 3'd1;
    localparam logic [2:0] ST_BADTS    = 3'd2;
    localparam logic [2:0] ST_BADCHECK = 3'd3;
    localparam logic [2:0] ST_TIMEOUT  = 3'd4;
    localparam logic [2:0] ST_TOOLONG  = 3'd5;
    localparam logic [2:0] ST_IDLE     = 3'd6;

    // Parse phases
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_TS    = 3'd1;
    localparam logic [2:0] PH_T0    = 3'd2;
    localparam logic [2:0] PH_IFACE = 3'd3;
    localparam logic [2:0] PH_HIST  = 3'd4;
    localparam logic [2:0] PH_TCK   = 3'd5;

    // TS characters for the two conventions (inverse seen in raw form)
    localparam logic [7:0] TS_DIRECT  = 8'h3B;
    localparam logic [7:0] TS_INVERSE = 8'h03;

    // Fi from the high nibble of TA1, zero for reserved codes
    function automatic logic [11:0] fi_decode(input logic [3:0] code);
        logic [11:0] fi;
        begin
            case (code)
                4'd0:    fi = 12'd372;
                4'd1:    fi = 12'd372;
                4'd2:    fi = 12'd558;
                4'd3:    fi = 12'd744;
                4'd4:    fi = 12'd1116;
                4'd5:    fi = 12'd1488;
                4'd6:    fi = 12'd1860;
                4'd9:    fi = 12'd512;
                4'd10:   fi = 12'd768;
                4'd11:   fi = 12'd1024;
                4'd12:   fi = 12'd1536;
                4'd13:   fi = 12'd2048;
                default: fi = 12'd0;
            endcase
            return fi;
        end
    endfunction

    // Di from the low nibble of TA1, zero for reserved codes
    function automatic logic [6:0] di_decode(input logic [3:0] code);
        logic [6:0] di;
        begin
            case (code)
                4'd1:    di = 7'd1;
                4'd2:    di = 7'd2;
                4'd3:    di = 7'd4;
                4'd4:    di = 7'd8;
                4'd5:    di = 7'd16;
                4'd6:    di = 7'd32;
                4'd7:    di = 7'd64;
                4'd8:    di = 7'd12;
                4'd9:    di = 7'd20;
                default: di = 7'd0;
            endcase
            return di;
        end
    endfunction

endpackage

### hdl/smartcard_atr_parser.sv
`timescale 1ns / 1ps

// Answer-to-reset parser for an ISO 7816-3 card interface.
// Slave channel: one transfer per event. tuser carries the kind (received
// character, start of a new answer-to-reset, character timeout) and tdata
// the received character. Master channel: one result per slave transfer, in
// order. tuser carries the status (more expected, complete, bad TS, check
// mismatch, timeout, too long, idle); tdata carries the byte position and
// the parameters captured so far (convention, T=1, extra guard time,
// waiting integer, Fi, Di, PPS hint, length received).
// An accepted transfer is captured in the input register, decoded, and
// moves into the result register once that slot is free, where it is
// offered on the master side. One transfer per cycle while the receiver
// takes results; the parse state is read and updated as each item moves on.
// The input register and the result register form two stages, so a new
// transfer is taken while a finished result waits on the master side.
// When the receiver stalls, both stages fill and s_axis_tready drops.
// Reset empties both stages, returns the parser to idle and loads the
// default parameters (waiting integer 10, group number 1, all else zero).
module smartcard_atr_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [5:0] byte_index, [6] convention, [7] protocol_t1, [15:8] guard_extra,
    // [23:16] wait_integer, [35:24] clock_rate_factor,
    // [42:36] baud_adjust_factor, [43] pps_needed, [49:44] atr_length,
    // [55:50] zero
    output logic [55:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser    // [2:0] status
);

    // Input stage
    logic       in_valid_reg;
    logic [1:0] in_mode_reg;
    logic [7:0] in_byte_reg;

    // Result stage
    logic        out_valid_reg;
    logic [2:0]  out_status_reg;
    logic [55:0] out_data_reg;

    // Parse state
    logic [2:0] phase_reg,        phase_next;
    logic [3:0] pending_mask_reg, pending_mask_next;
    logic [3:0] group_number_reg, group_number_next;
    logic [3:0] history_left_reg, history_left_next;
    logic [7:0] running_xor_reg,  running_xor_next;
    logic       check_req_reg,    check_req_next;
    logic [7:0] first_ta_reg,     first_ta_next;
    logic [7:0] guard_reg,        guard_next;
    logic [7:0] wait_reg,         wait_next;
    logic       t1_reg,           t1_next;
    logic       inverse_reg,      inverse_next;
    logic [5:0] byte_count_reg,   byte_count_next;

    logic        advance;
    logic        do_route;
    logic [2:0]  status;
    logic [5:0]  index;
    logic [11:0] fi;
    logic [6:0]  di;
    logic        pps;
    logic [55:0] result_data;

    // Move the input stage into the result stage when the result slot frees
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;

    // Compute the next parse state and the status for the registered item
    always_comb
    begin
        phase_next        = phase_reg;
        pending_mask_next = pending_mask_reg;
        group_number_next = group_number_reg;
        history_left_next = history_left_reg;
        running_xor_next  = running_xor_reg;
        check_req_next    = check_req_reg;
        first_ta_next     = first_ta_reg;
        guard_next        = guard_reg;
        wait_next         = wait_reg;
        t1_next           = t1_reg;
        inverse_next      = inverse_reg;
        byte_count_next   = byte_count_reg;
        status            = smcatr_pkg::ST_MORE;
        index             = byte_count_reg;
        do_route          = 1'b0;

        if (in_mode_reg == smcatr_pkg::MODE_START)
        begin
            // Clear everything and wait for TS
            pending_mask_next = 4'd0;
            group_number_next = 4'd1;
            history_left_next = 4'd0;
            running_xor_next  = 8'd0;
            check_req_next    = 1'b0;
            first_ta_next     = 8'd0;
            guard_next        = 8'd0;
            wait_next         = smcatr_pkg::WAIT_DEFAULT;
            t1_next           = 1'b0;
            inverse_next      = 1'b0;
            byte_count_next   = 6'd0;
            phase_next        = smcatr_pkg::PH_TS;
            index             = 6'd0;
        end
        else if (phase_reg == smcatr_pkg::PH_IDLE || phase_reg > smcatr_pkg::PH_TCK)
        begin
            phase_next = smcatr_pkg::PH_IDLE;
            status     = smcatr_pkg::ST_IDLE;
        end
        else if (in_mode_reg == smcatr_pkg::MODE_TIMEOUT)
        begin
            phase_next = smcatr_pkg::PH_IDLE;
            status     = smcatr_pkg::ST_TIMEOUT;
        end
        else if (in_mode_reg == smcatr_pkg::MODE_BYTE)
        begin
            if (byte_count_reg >= smcatr_pkg::MAX_ATR_BYTES)
            begin
                phase_next = smcatr_pkg::PH_IDLE;
                status     = smcatr_pkg::ST_TOOLONG;
            end
            else
            begin
                byte_count_next = byte_count_reg + 6'd1;
                case (phase_reg)
                    smcatr_pkg::PH_TS:
                    begin
                        if (in_byte_reg == smcatr_pkg::TS_DIRECT)
                        begin
                            inverse_next = 1'b0;
                            phase_next   = smcatr_pkg::PH_T0;
                        end
                        else if (in_byte_reg == smcatr_pkg::TS_INVERSE)
                        begin
                            inverse_next = 1'b1;
                            phase_next   = smcatr_pkg::PH_T0;
                        end
                        else
                        begin
                            phase_next = smcatr_pkg::PH_IDLE;
                            status     = smcatr_pkg::ST_BADTS;
                        end
                    end
                    smcatr_pkg::PH_T0:
                    begin
                        running_xor_next  = in_byte_reg;
                        history_left_next = in_byte_reg[3:0];
                        pending_mask_next = in_byte_reg[7:4];
                        group_number_next = 4'd1;
                        do_route          = 1'b1;
                    end
                    smcatr_pkg::PH_IFACE:
                    begin
                        running_xor_next = running_xor_reg ^ in_byte_reg;
                        // Take the lowest pending interface byte of the group
                        if (pending_mask_reg[0])
                        begin
                            pending_mask_next = pending_mask_reg & 4'b1110;
                            if (group_number_reg == 4'd1)
                                first_ta_next = in_byte_reg;
                        end
                        else if (pending_mask_reg[1])
                        begin
                            pending_mask_next = pending_mask_reg & 4'b1101;
                        end
                        else if (pending_mask_reg[2])
                        begin
                            pending_mask_next = pending_mask_reg & 4'b1011;
                            if (group_number_reg == 4'd1)
                                guard_next = (in_byte_reg == 8'hFF) ? 8'd0 : in_byte_reg;
                            else if (group_number_reg == 4'd2)
                                wait_next = in_byte_reg;
                        end
                        else
                        begin
                            if (in_byte_reg[3:0] == 4'd0)
                                t1_next = 1'b0;
                            else if (in_byte_reg[3:0] == 4'd1)
                                t1_next = 1'b1;
                            if (in_byte_reg[3:0] != 4'd0)
                                check_req_next = 1'b1;
                            pending_mask_next = in_byte_reg[7:4];
                            if (group_number_reg != 4'd15)
                                group_number_next = group_number_reg + 4'd1;
                        end
                        do_route = 1'b1;
                    end
                    smcatr_pkg::PH_HIST:
                    begin
                        running_xor_next = running_xor_reg ^ in_byte_reg;
                        if (history_left_reg != 4'd0)
                            history_left_next = history_left_reg - 4'd1;
                        do_route = 1'b1;
                    end
                    default:
                    begin
                        // Check byte: whole XOR from T0 on must vanish
                        running_xor_next = running_xor_reg ^ in_byte_reg;
                        phase_next       = smcatr_pkg::PH_IDLE;
                        status           = (running_xor_next != 8'd0) ?
                                           smcatr_pkg::ST_BADCHECK : smcatr_pkg::ST_DONE;
                    end
                endcase

                // Route to interface bytes, history, check byte or finish
                if (do_route)
                begin
                    if (pending_mask_next != 4'd0)
                        phase_next = smcatr_pkg::PH_IFACE;
                    else if (history_left_next != 4'd0)
                        phase_next = smcatr_pkg::PH_HIST;
                    else if (check_req_next)
                        phase_next = smcatr_pkg::PH_TCK;
                    else
                    begin
                        phase_next = smcatr_pkg::PH_IDLE;
                        status     = smcatr_pkg::ST_DONE;
                    end
                end
            end
        end
    end

    // Decode TA1 into the speed parameters
    always_comb
    begin
        fi  = smcatr_pkg::fi_decode(first_ta_next[7:4]);
        di  = smcatr_pkg::di_decode(first_ta_next[3:0]);
        pps = !(first_ta_next == 8'h00 || first_ta_next == 8'h01 ||
                first_ta_next == 8'h11 || fi == 12'd0 || di == 7'd0);
        result_data = {6'd0, byte_count_next, pps, di, fi, wait_next, guard_next,
                       t1_next, inverse_next, index};
    end

    // Capture an accepted transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_mode_reg <= s_axis_tuser;
            in_byte_reg <= s_axis_tdata;
        end
    end

    // Hold the result until the master side takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_status_reg <= status;
            out_data_reg   <= result_data;
        end
    end

    // Commit the parse state when the item leaves the input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= smcatr_pkg::PH_IDLE;
            pending_mask_reg <= 4'd0;
            group_number_reg <= 4'd1;
            history_left_reg <= 4'd0;
            running_xor_reg  <= 8'd0;
            check_req_reg    <= 1'b0;
            first_ta_reg     <= 8'd0;
            guard_reg        <= 8'd0;
            wait_reg         <= smcatr_pkg::WAIT_DEFAULT;
            t1_reg           <= 1'b0;
            inverse_reg      <= 1'b0;
            byte_count_reg   <= 6'd0;
        end
        else if (advance)
        begin
            phase_reg        <= phase_next;
            pending_mask_reg <= pending_mask_next;
            group_number_reg <= group_number_next;
            history_left_reg <= history_left_next;
            running_xor_reg  <= running_xor_next;
            check_req_reg    <= check_req_next;
            first_ta_reg     <= first_ta_next;
            guard_reg        <= guard_next;
            wait_reg         <= wait_next;
            t1_reg           <= t1_next;
            inverse_reg      <= inverse_next;
            byte_count_reg   <= byte_count_next;
        end
    end

    // Length never runs past the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= smcatr_pkg::MAX_ATR_BYTES)
    else $error("byte count beyond limit");

    // A final status leaves the parser idle
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && (status == smcatr_pkg::ST_DONE || status == smcatr_pkg::ST_BADTS ||
                    status == smcatr_pkg::ST_BADCHECK || status == smcatr_pkg::ST_TIMEOUT ||
                    status == smcatr_pkg::ST_TOOLONG)
        |=> phase_reg == smcatr_pkg::PH_IDLE)
    else $error("parser not idle after final status");

    // A start transfer opens a fresh parse waiting for TS
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_mode_reg == smcatr_pkg::MODE_START
        |=> phase_reg == smcatr_pkg::PH_TS && byte_count_reg == 6'd0)
    else $error("start did not reset the parse");

    // Backpressure only when both stages are full and the receiver stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg && out_valid_reg && !m_axis_tready)
    else $error("input stalled without cause");

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    // Mode code the block does not define
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // Shapes of generated answer-to-reset sequences
    localparam int SHAPE_NORMAL = 0;
    localparam int SHAPE_CUT    = 1;
    localparam int SHAPE_LONG   = 2;
    localparam int SHAPE_CHAIN  = 3;

    localparam int ITEM_GOAL = 850;

    typedef struct packed {
        logic       drain;    // marker: hold the sender until all results are back
        logic [1:0] mode;
        logic [7:0] data;
    } stim_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  byte_pos;
        logic        convention;
        logic        t1;
        logic [7:0]  guard;
        logic [7:0]  wait_int;
        logic [11:0] fi;
        logic [6:0]  di;
        logic        pps;
        logic [5:0]  length;
        logic [5:0]  pad;
    } atr_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] rx_byte
    logic [1:0]  s_axis_tuser = 2'd0;    // [1:0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;           // byte_index .. atr_length, see dut ports
    logic [2:0]  m_axis_tuser;           // [2:0] status

    smartcard_atr_parser dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Parser state mirror
    logic [2:0] prs_phase     = smcatr_pkg::PH_IDLE;
    logic [3:0] prs_mask      = 4'h0;
    logic [3:0] prs_group     = 4'd1;
    logic [3:0] prs_hist      = 4'h0;
    logic [7:0] prs_xor       = 8'h00;
    logic       prs_need_tck  = 1'b0;
    logic [7:0] prs_ta1       = 8'h00;
    logic [7:0] prs_guard     = 8'h00;
    logic [7:0] prs_wait      = smcatr_pkg::WAIT_DEFAULT;
    logic       prs_t1        = 1'b0;
    logic       prs_inverse   = 1'b0;
    logic [5:0] prs_count     = 6'd0;

    stim_t       stim_q[$];
    atr_result_t expect_q[$];

    logic in_fire = 1'b0;
    int   gen_count = 0;
    int   tx_gap = 0;
    int   tx_calm = 0;
    int   rx_hold = 0;
    int   rx_calm = 0;
    bit   long_hold_done = 1'b0;
    int   items_taken = 0;
    int   results_seen = 0;
    int   mismatches = 0;
    int   status_hits[8];

    function automatic logic [11:0] clock_factor(input logic [3:0] code);
        case (code)
            4'd0, 4'd1: return 12'd372;
            4'd2:       return 12'd558;
            4'd3:       return 12'd744;
            4'd4:       return 12'd1116;
            4'd5:       return 12'd1488;
            4'd6:       return 12'd1860;
            4'd9:       return 12'd512;
            4'd10:      return 12'd768;
            4'd11:      return 12'd1024;
            4'd12:      return 12'd1536;
            4'd13:      return 12'd2048;
            default:    return 12'd0;
        endcase
    endfunction

    function automatic logic [6:0] baud_factor(input logic [3:0] code);
        case (code)
            4'd1:    return 7'd1;
            4'd2:    return 7'd2;
            4'd3:    return 7'd4;
            4'd4:    return 7'd8;
            4'd5:    return 7'd16;
            4'd6:    return 7'd32;
            4'd7:    return 7'd64;
            4'd8:    return 7'd12;
            4'd9:    return 7'd20;
            default: return 7'd0;
        endcase
    endfunction

    // Move on after an interface or historical character
    function automatic logic [2:0] pick_next_phase();
        if (prs_mask != 4'h0)
        begin
            prs_phase = smcatr_pkg::PH_IFACE;
            return smcatr_pkg::ST_MORE;
        end
        if (prs_hist != 4'h0)
        begin
            prs_phase = smcatr_pkg::PH_HIST;
            return smcatr_pkg::ST_MORE;
        end
        if (prs_need_tck)
        begin
            prs_phase = smcatr_pkg::PH_TCK;
            return smcatr_pkg::ST_MORE;
        end
        prs_phase = smcatr_pkg::PH_IDLE;
        return smcatr_pkg::ST_DONE;
    endfunction

    // Advance the mirror by one transfer and return the result it should produce
    function automatic atr_result_t parse_step(input logic [1:0] mode, input logic [7:0] b);
        atr_result_t r;
        logic [5:0]  pos;
        logic [2:0]  st;
        logic [3:0]  proto;
        pos = prs_count;
        if (mode == smcatr_pkg::MODE_START)
        begin
            prs_mask     = 4'h0;
            prs_group    = 4'd1;
            prs_hist     = 4'h0;
            prs_xor      = 8'h00;
            prs_need_tck = 1'b0;
            prs_ta1      = 8'h00;
            prs_guard    = 8'h00;
            prs_wait     = smcatr_pkg::WAIT_DEFAULT;
            prs_t1       = 1'b0;
            prs_inverse  = 1'b0;
            prs_count    = 6'd0;
            prs_phase    = smcatr_pkg::PH_TS;
            pos          = 6'd0;
            st           = smcatr_pkg::ST_MORE;
        end
        else if (prs_phase == smcatr_pkg::PH_IDLE || prs_phase > smcatr_pkg::PH_TCK)
        begin
            prs_phase = smcatr_pkg::PH_IDLE;
            st = smcatr_pkg::ST_IDLE;
        end
        else if (mode == smcatr_pkg::MODE_TIMEOUT)
        begin
            prs_phase = smcatr_pkg::PH_IDLE;
            st = smcatr_pkg::ST_TIMEOUT;
        end
        else if (mode == smcatr_pkg::MODE_BYTE)
        begin
            if (prs_count >= smcatr_pkg::MAX_ATR_BYTES)
            begin
                // too long: the character is dropped, not counted
                prs_phase = smcatr_pkg::PH_IDLE;
                st = smcatr_pkg::ST_TOOLONG;
            end
            else
            begin
                prs_count = prs_count + 6'd1;
                case (prs_phase)
                    smcatr_pkg::PH_TS:
                    begin
                        if (b == smcatr_pkg::TS_DIRECT)
                        begin
                            prs_inverse = 1'b0;
                            prs_phase = smcatr_pkg::PH_T0;
                            st = smcatr_pkg::ST_MORE;
                        end
                        else if (b == smcatr_pkg::TS_INVERSE)
                        begin
                            prs_inverse = 1'b1;
                            prs_phase = smcatr_pkg::PH_T0;
                            st = smcatr_pkg::ST_MORE;
                        end
                        else
                        begin
                            prs_phase = smcatr_pkg::PH_IDLE;
                            st = smcatr_pkg::ST_BADTS;
                        end
                    end
                    smcatr_pkg::PH_T0:
                    begin
                        prs_xor   = b;
                        prs_hist  = b[3:0];
                        prs_mask  = b[7:4];
                        prs_group = 4'd1;
                        st = pick_next_phase();
                    end
                    smcatr_pkg::PH_IFACE:
                    begin
                        prs_xor ^= b;
                        // interface characters come in TA, TB, TC, TD order
                        if (prs_mask[0])
                        begin
                            prs_mask[0] = 1'b0;
                            if (prs_group == 4'd1)
                                prs_ta1 = b;
                        end
                        else if (prs_mask[1])
                        begin
                            prs_mask[1] = 1'b0;
                        end
                        else if (prs_mask[2])
                        begin
                            prs_mask[2] = 1'b0;
                            if (prs_group == 4'd1)
                                prs_guard = (b == 8'hFF) ? 8'h00 : b;
                            else if (prs_group == 4'd2)
                                prs_wait = b;
                        end
                        else
                        begin
                            proto = b[3:0];
                            if (proto == 4'd0)
                                prs_t1 = 1'b0;
                            else if (proto == 4'd1)
                                prs_t1 = 1'b1;
                            if (proto != 4'd0)
                                prs_need_tck = 1'b1;
                            prs_mask = b[7:4];
                            if (prs_group < 4'd15)
                                prs_group = prs_group + 4'd1;
                        end
                        st = pick_next_phase();
                    end
                    smcatr_pkg::PH_HIST:
                    begin
                        prs_xor ^= b;
                        if (prs_hist != 4'h0)
                            prs_hist = prs_hist - 4'd1;
                        st = pick_next_phase();
                    end
                    default:
                    begin
                        prs_xor ^= b;
                        prs_phase = smcatr_pkg::PH_IDLE;
                        st = (prs_xor != 8'h00) ? smcatr_pkg::ST_BADCHECK
                                                : smcatr_pkg::ST_DONE;
                    end
                endcase
            end
        end
        else
        begin
            // spare mode: no change
            st = smcatr_pkg::ST_MORE;
        end

        r.status     = st;
        r.byte_pos   = pos;
        r.convention = prs_inverse;
        r.t1         = prs_t1;
        r.guard      = prs_guard;
        r.wait_int   = prs_wait;
        r.fi         = clock_factor(prs_ta1[7:4]);
        r.di         = baud_factor(prs_ta1[3:0]);
        r.pps        = !(prs_ta1 == 8'h00 || prs_ta1 == 8'h01 || prs_ta1 == 8'h11 ||
                         r.fi == 12'd0 || r.di == 7'd0);
        r.length     = prs_count;
        r.pad        = 6'd0;
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Sender gap after a transfer: mostly short, a few long, some calm stretches
    function automatic int next_gap();
        int k;
        if (tx_calm > 0)
        begin
            tx_calm--;
            return 0;
        end
        k = $urandom_range(0, 99);
        if (k < 2)
        begin
            tx_calm = $urandom_range(20, 60);
            return 0;
        end
        if (k < 57)
            return 0;
        if (k < 90)
            return $urandom_range(1, 3);
        if (k < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    task automatic push_item(input logic [1:0] mode, input logic [7:0] data);
        stim_t s;
        s.drain = 1'b0;
        s.mode  = mode;
        s.data  = data;
        stim_q.push_back(s);
        gen_count++;
    endtask

    // Queue one answer-to-reset with random content
    task automatic build_atr(input int shape);
        logic [7:0] seq[$];
        logic [7:0] b;
        logic [7:0] sum;
        logic [3:0] mask;
        logic [3:0] next_mask;
        logic [3:0] proto;
        bit         need_check;
        int         k;
        int         g;
        int         last_group;
        int         n_hist;
        int         cut;

        need_check = 1'b0;
        k = $urandom_range(0, 19);
        if (shape == SHAPE_LONG)
            k = 1;
        if (k == 0)
            seq.push_back(8'($urandom));
        else if (k < 10)
            seq.push_back(smcatr_pkg::TS_DIRECT);
        else
            seq.push_back(smcatr_pkg::TS_INVERSE);

        case (shape)
            SHAPE_LONG:
            begin
                mask = 4'hF;
                n_hist = 15;
                last_group = 4;
            end
            SHAPE_CHAIN:
            begin
                mask = 4'h8;
                n_hist = $urandom_range(0, 3);
                last_group = $urandom_range(12, 20);
            end
            default:
            begin
                mask = 4'($urandom);
                n_hist = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                     : $urandom_range(0, 4);
                last_group = $urandom_range(1, 3);
            end
        endcase
        seq.push_back({mask, 4'(n_hist)});

        // interface groups
        g = 1;
        while (mask != 4'h0)
        begin
            if (mask[0])
            begin
                b = 8'($urandom);
                if (g == 1 && $urandom_range(0, 4) == 0)
                begin
                    k = $urandom_range(0, 2);
                    b = (k == 0) ? 8'h00 : ((k == 1) ? 8'h01 : 8'h11);
                end
                seq.push_back(b);
            end
            if (mask[1])
                seq.push_back(8'($urandom));
            if (mask[2])
                seq.push_back(($urandom_range(0, 4) == 0) ? 8'hFF : 8'($urandom));
            if (mask[3])
            begin
                if (shape == SHAPE_LONG)
                begin
                    next_mask = (g < last_group) ? 4'hF : 4'h0;
                    proto = 4'd1;
                end
                else
                begin
                    if (shape == SHAPE_CHAIN)
                        next_mask = (g < last_group) ? 4'h8 : 4'h0;
                    else
                        next_mask = (g < last_group) ? 4'($urandom) : 4'h0;
                    k = $urandom_range(0, 9);
                    proto = (k < 4) ? 4'd0 : ((k < 8) ? 4'd1 : 4'($urandom_range(2, 15)));
                end
                if (proto != 4'd0)
                    need_check = 1'b1;
                seq.push_back({next_mask, proto});
                mask = next_mask;
            end
            else
            begin
                mask = 4'h0;
            end
            g++;
        end

        // historical characters and check character
        for (int i = 0; i < n_hist; i++)
            seq.push_back(8'($urandom));
        if (need_check)
        begin
            sum = 8'h00;
            for (int i = 1; i < seq.size(); i++)
                sum ^= seq[i];
            if ($urandom_range(0, 9) == 0)
                sum ^= 8'($urandom_range(1, 255));
            seq.push_back(sum);
        end
        if (shape == SHAPE_LONG)
            seq.push_back(8'($urandom));

        push_item(smcatr_pkg::MODE_START, 8'($urandom));
        if (shape == SHAPE_CUT)
        begin
            cut = $urandom_range(0, seq.size() - 1);
            for (int i = 0; i < cut; i++)
                push_item(smcatr_pkg::MODE_BYTE, seq[i]);
            k = $urandom_range(0, 2);
            if (k == 1)
                push_item(MODE_SPARE, 8'($urandom));
            if (k != 2)
                push_item(smcatr_pkg::MODE_TIMEOUT, 8'($urandom));
        end
        else
        begin
            foreach (seq[i])
                push_item(smcatr_pkg::MODE_BYTE, seq[i]);
        end
    endtask

    // Clock
    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Sender: one transfer at a time from the pending queue
    always @(negedge clk)
    begin : drive_input
        stim_t      nxt;
        logic       nv;
        logic [1:0] nm;
        logic [7:0] nd;
        if (rst_n)
        begin
            nv = s_axis_tvalid;
            nm = s_axis_tuser;
            nd = s_axis_tdata;
            if (!s_axis_tvalid || in_fire)
            begin
                nv = 1'b0;
                if (tx_gap > 0)
                begin
                    tx_gap--;
                end
                else if (stim_q.size() != 0)
                begin
                    if (!stim_q[0].drain)
                    begin
                        nxt = stim_q.pop_front();
                        nv = 1'b1;
                        nm = nxt.mode;
                        nd = nxt.data;
                        tx_gap = next_gap();
                    end
                    else if (expect_q.size() == 0)
                    begin
                        stim_q.delete(0);
                    end
                end
            end
            s_axis_tvalid <= nv;
            s_axis_tuser  <= nm;
            s_axis_tdata  <= nd;
        end
    end

    // Receiver: random stalls plus one long hold-off
    always @(negedge clk)
    begin : drive_ready
        int k;
        if (rst_n)
        begin
            if (!long_hold_done && results_seen >= 200)
            begin
                long_hold_done = 1'b1;
                rx_hold = 150;
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                m_axis_tready <= 1'b0;
            end
            else if (rx_calm > 0)
            begin
                rx_calm--;
                m_axis_tready <= 1'b1;
            end
            else
            begin
                k = $urandom_range(0, 99);
                if (k < 2)
                    rx_calm = $urandom_range(20, 60);
                else if (k >= 95 && k < 98)
                    rx_hold = $urandom_range(3, 10);
                else if (k >= 98)
                    rx_hold = $urandom_range(20, 40);
                m_axis_tready <= (k < 60);
            end
        end
    end

    // Monitor: predict on input transfers, check on output transfers
    always @(posedge clk)
    begin : watch
        atr_result_t want;
        atr_result_t got;
        if (!rst_n)
        begin
            in_fire <= 1'b0;
        end
        else
        begin
            in_fire <= s_axis_tvalid && s_axis_tready;
            // check first so a same-edge input never matches its own result
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (expect_q.size() == 0)
                begin
                    $error("unexpected result transfer: status %0d", m_axis_tuser);
                    mismatches++;
                end
                else
                begin
                    want = expect_q.pop_front();
                    got.status     = m_axis_tuser;
                    got.byte_pos   = m_axis_tdata[5:0];
                    got.convention = m_axis_tdata[6];
                    got.t1         = m_axis_tdata[7];
                    got.guard      = m_axis_tdata[15:8];
                    got.wait_int   = m_axis_tdata[23:16];
                    got.fi         = m_axis_tdata[35:24];
                    got.di         = m_axis_tdata[42:36];
                    got.pps        = m_axis_tdata[43];
                    got.length     = m_axis_tdata[49:44];
                    got.pad        = m_axis_tdata[55:50];
                    check_field("status", want.status, got.status);
                    check_field("byte_index", want.byte_pos, got.byte_pos);
                    check_field("convention", want.convention, got.convention);
                    check_field("protocol_t1", want.t1, got.t1);
                    check_field("guard_extra", want.guard, got.guard);
                    check_field("wait_integer", want.wait_int, got.wait_int);
                    check_field("clock_rate_factor", want.fi, got.fi);
                    check_field("baud_adjust_factor", want.di, got.di);
                    check_field("pps_needed", want.pps, got.pps);
                    check_field("atr_length", want.length, got.length);
                    check_field("tdata padding", want.pad, got.pad);
                    status_hits[got.status]++;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                expect_q.push_back(parse_step(s_axis_tuser, s_axis_tdata));
                items_taken++;
            end
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        stim_t mark;
        int    sel;
        bit    drained;

        // idle handling right after reset
        push_item(smcatr_pkg::MODE_BYTE, 8'hA5);
        push_item(smcatr_pkg::MODE_TIMEOUT, 8'h5A);
        push_item(MODE_SPARE, 8'hFF);
        // bad TS: raw 0x3F is not the inverse form
        push_item(smcatr_pkg::MODE_START, 8'h00);
        push_item(smcatr_pkg::MODE_BYTE, 8'h3F);
        // shortest answer-to-reset
        push_item(smcatr_pkg::MODE_START, 8'hFF);
        push_item(smcatr_pkg::MODE_BYTE, smcatr_pkg::TS_DIRECT);
        push_item(smcatr_pkg::MODE_BYTE, 8'h00);
        // inverse, all TA1..TD1, TC2 = 0xFF, T=1 then T=14, two historicals, TCK
        push_item(smcatr_pkg::MODE_START, 8'h00);
        push_item(smcatr_pkg::MODE_BYTE, smcatr_pkg::TS_INVERSE);
        push_item(smcatr_pkg::MODE_BYTE, 8'hF2);
        push_item(smcatr_pkg::MODE_BYTE, 8'hD7);
        push_item(smcatr_pkg::MODE_BYTE, 8'h00);
        push_item(smcatr_pkg::MODE_BYTE, 8'hFF);
        push_item(smcatr_pkg::MODE_BYTE, 8'hC1);
        push_item(smcatr_pkg::MODE_BYTE, 8'hFF);
        push_item(smcatr_pkg::MODE_BYTE, 8'h0E);
        push_item(smcatr_pkg::MODE_BYTE, 8'h80);
        push_item(smcatr_pkg::MODE_BYTE, 8'h01);
        push_item(smcatr_pkg::MODE_BYTE, 8'h6B);
        // spare mode and timeout in the middle of a parse
        push_item(smcatr_pkg::MODE_START, 8'h00);
        push_item(smcatr_pkg::MODE_BYTE, smcatr_pkg::TS_DIRECT);
        push_item(MODE_SPARE, 8'h00);
        push_item(smcatr_pkg::MODE_BYTE, 8'h10);
        push_item(smcatr_pkg::MODE_TIMEOUT, 8'h00);

        mark.drain = 1'b1;
        mark.mode  = smcatr_pkg::MODE_BYTE;
        mark.data  = 8'h00;
        stim_q.push_back(mark);

        // random part, led by one over-length sequence
        drained = 1'b0;
        build_atr(SHAPE_LONG);
        while (gen_count < ITEM_GOAL)
        begin
            if (!drained && gen_count > 450)
            begin
                stim_q.push_back(mark);
                drained = 1'b1;
            end
            sel = $urandom_range(0, 99);
            if (sel < 76)
                build_atr(SHAPE_NORMAL);
            else if (sel < 86)
                build_atr(SHAPE_CUT);
            else if (sel < 92)
            begin
                // noise: any mode, any data, not counted
                repeat ($urandom_range(1, 4))
                begin
                    mark.drain = 1'b0;
                    mark.mode  = 2'($urandom);
                    mark.data  = 8'($urandom);
                    stim_q.push_back(mark);
                end
                mark.drain = 1'b1;
            end
            else if (sel < 96)
                build_atr(SHAPE_LONG);
            else
                build_atr(SHAPE_CHAIN);
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (stim_q.size() != 0 || s_axis_tvalid || expect_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Run covered %0d input transfers and %0d checked results, %0d mismatches",
                 items_taken, results_seen, mismatches);
        $display("Outcomes: complete %0d, bad TS %0d, check mismatch %0d, timeout %0d, %s %0d",
                 status_hits[smcatr_pkg::ST_DONE], status_hits[smcatr_pkg::ST_BADTS],
                 status_hits[smcatr_pkg::ST_BADCHECK], status_hits[smcatr_pkg::ST_TIMEOUT],
                 "too long", status_hits[smcatr_pkg::ST_TOOLONG]);
        if (mismatches == 0 && expect_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
